>>> rtl/core/page_frame_free_stack_unit_macros.svh
// ----------------------------------------------------------------------------
// Page frame free stack: assertion macros
// Shared concurrent assertion forms for the checker of the frame allocator.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_FREE_STACK_UNIT_MACROS_SVH
`define PAGE_FRAME_FREE_STACK_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PFFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PFFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pffs_pkg.sv
// ----------------------------------------------------------------------------
// Page frame free stack: package
// Field widths, default parameters, sequencer states and RAM control type.
// ----------------------------------------------------------------------------
package pffs_pkg;

  // Default sizing of the allocator.
  localparam int DEF_STACK_DEPTH  = 4096;
  localparam int DEF_ADDRESS_BITS = 40;
  localparam int DEF_PAGE_SHIFT   = 12;

  // Fixed widths of the port fields.
  localparam int ADDR_FIELD_W  = 40;
  localparam int COUNT_FIELD_W = 13;
  localparam int TYPE_W        = 4;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP
  } state_t;

  // Control of the single-port frame RAM.
  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

>>> rtl/core/pffs_mem.sv
// ----------------------------------------------------------------------------
// Page frame free stack: frame RAM
// Single-port synchronous RAM holding frame numbers, with a registered read.
// ----------------------------------------------------------------------------
module pffs_mem
  import pffs_pkg::*;
#(
  parameter int DEPTH = DEF_STACK_DEPTH,
  parameter int WIDTH = DEF_ADDRESS_BITS - DEF_PAGE_SHIFT
) (
  input  logic                     clk,
  input  mem_ctl_t                 mem_ctl,
  input  logic [$clog2(DEPTH)-1:0] mem_addr,
  input  logic [WIDTH-1:0]         mem_wdata,
  output logic [WIDTH-1:0]         mem_rdata
);

  logic [WIDTH-1:0] frame_ram_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle: a write, or a read that lands in the data register.
  always_ff @(posedge clk) begin
    if (mem_ctl.en) begin
      if (mem_ctl.we) begin
        frame_ram_r[mem_addr] <= mem_wdata;
      end else begin
        rdata_r <= frame_ram_r[mem_addr];
      end
    end
  end

  assign mem_rdata = rdata_r;

endmodule

>>> rtl/core/pffs_ctrl.sv
// ----------------------------------------------------------------------------
// Page frame free stack: control
// Stack pointer, push and pop sequencer, configuration and result registers.
// ----------------------------------------------------------------------------
module pffs_ctrl
  import pffs_pkg::*;
#(
  parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  parameter int PAGE_SHIFT   = DEF_PAGE_SHIFT,
  localparam int FW          = ADDRESS_BITS - PAGE_SHIFT,
  localparam int IW          = $clog2(STACK_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_opcode,
  input  logic [ADDR_FIELD_W-1:0]  in_region_base,
  input  logic [ADDR_FIELD_W-1:0]  in_region_length,
  input  logic [TYPE_W-1:0]        in_region_type,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [TYPE_W-1:0]        cfg_usable_type_code,
  output logic                     out_valid,
  output logic [ADDR_FIELD_W-1:0]  out_frame_address,
  output logic                     out_granted,
  output logic [COUNT_FIELD_W-1:0] out_pages_added,
  output logic                     out_pages_dropped,
  output logic [COUNT_FIELD_W-1:0] out_free_frames,
  output mem_ctl_t                 mem_ctl,
  output logic [IW-1:0]            mem_addr,
  output logic [FW-1:0]            mem_wdata,
  input  logic [FW-1:0]            mem_rdata
);

  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int PW   = ADDR_FIELD_W + 1 - PAGE_SHIFT;
  localparam int CMPW = (PW > CW) ? PW : CW;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [FW-1:0]            frame_r, frame_nxt;
  logic [CW-1:0]            remain_r, remain_nxt;
  logic [CW-1:0]            added_r, added_nxt;
  logic                     dropped_r, dropped_nxt;
  logic [TYPE_W-1:0]        utc_r, utc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [ADDR_FIELD_W-1:0]  out_addr_r, out_addr_nxt;
  logic                     out_granted_r, out_granted_nxt;
  logic [COUNT_FIELD_W-1:0] out_added_r, out_added_nxt;
  logic                     out_dropped_r, out_dropped_nxt;
  logic [COUNT_FIELD_W-1:0] out_free_r, out_free_nxt;

  logic                     accept;
  logic [ADDRESS_BITS-1:0]  base_w;
  logic [FW-1:0]            in_frame;
  logic [PW-1:0]            pages;
  logic [CMPW-1:0]          pages_c;
  logic [CMPW-1:0]          room_c;
  logic [CW-1:0]            take;
  logic                     type_ok;
  logic                     overflow;
  logic [CW-1:0]            count_inc;
  logic [CW-1:0]            count_dec;
  logic [ADDRESS_BITS-1:0]  pop_addr;

  // Region arithmetic: first frame, page count rounded up, room left on the stack.
  always_comb begin
    base_w    = ADDRESS_BITS'(in_region_base);
    in_frame  = base_w[ADDRESS_BITS-1:PAGE_SHIFT];
    pages     = PW'(in_region_length >> PAGE_SHIFT)
              + PW'(|in_region_length[PAGE_SHIFT-1:0]);
    pages_c   = CMPW'(pages);
    room_c    = CMPW'(CW'(STACK_DEPTH) - count_r);
    take      = (pages_c < room_c) ? CW'(pages_c) : CW'(room_c);
    overflow  = pages_c > room_c;
    type_ok   = in_region_type == utc_r;
    count_inc = count_r + CW'(1);
    count_dec = count_r - CW'(1);
    pop_addr  = {mem_rdata, {PAGE_SHIFT{1'b0}}};
  end

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = state_r == ST_IDLE;

  // Sequencer. Reads happen only when idle and writes only while pushing, so
  // a RAM read never overlaps a write of the same entry.
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    frame_nxt       = frame_r;
    remain_nxt      = remain_r;
    added_nxt       = added_r;
    dropped_nxt     = dropped_r;
    utc_nxt         = utc_r;
    out_valid_nxt   = 1'b0;
    out_addr_nxt    = out_addr_r;
    out_granted_nxt = out_granted_r;
    out_added_nxt   = out_added_r;
    out_dropped_nxt = out_dropped_r;
    out_free_nxt    = out_free_r;
    mem_ctl         = '0;
    mem_addr        = IW'(count_r);
    mem_wdata       = frame_r;

    if (cfg_valid && cfg_ready) begin
      utc_nxt = cfg_usable_type_code;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode) begin
            if (count_r != '0) begin
              // Pop: read the top entry, the result follows the read data.
              mem_ctl.en = 1'b1;
              mem_addr   = IW'(count_dec);
              count_nxt  = count_dec;
              state_nxt  = ST_POP;
            end else begin
              // Request on an empty stack.
              out_valid_nxt   = 1'b1;
              out_addr_nxt    = '0;
              out_granted_nxt = 1'b0;
              out_added_nxt   = '0;
              out_dropped_nxt = 1'b0;
              out_free_nxt    = COUNT_FIELD_W'(count_r);
            end
          end else if (type_ok && (take != '0)) begin
            frame_nxt   = in_frame;
            remain_nxt  = take;
            added_nxt   = take;
            dropped_nxt = overflow;
            state_nxt   = ST_PUSH;
          end else begin
            // Registration that pushes nothing.
            out_valid_nxt   = 1'b1;
            out_addr_nxt    = '0;
            out_granted_nxt = 1'b0;
            out_added_nxt   = '0;
            out_dropped_nxt = type_ok && overflow;
            out_free_nxt    = COUNT_FIELD_W'(count_r);
          end
        end
      end
      ST_PUSH: begin
        // One page per cycle at the stack pointer.
        mem_ctl.en = 1'b1;
        mem_ctl.we = 1'b1;
        count_nxt  = count_inc;
        frame_nxt  = frame_r + FW'(1);
        remain_nxt = remain_r - CW'(1);
        if (remain_r == CW'(1)) begin
          out_valid_nxt   = 1'b1;
          out_addr_nxt    = '0;
          out_granted_nxt = 1'b0;
          out_added_nxt   = COUNT_FIELD_W'(added_r);
          out_dropped_nxt = dropped_r;
          out_free_nxt    = COUNT_FIELD_W'(count_inc);
          state_nxt       = ST_IDLE;
        end
      end
      ST_POP: begin
        out_valid_nxt   = 1'b1;
        out_addr_nxt    = ADDR_FIELD_W'(pop_addr);
        out_granted_nxt = 1'b1;
        out_added_nxt   = '0;
        out_dropped_nxt = 1'b0;
        out_free_nxt    = COUNT_FIELD_W'(count_r);
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      utc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      utc_r       <= utc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk) begin
    frame_r       <= frame_nxt;
    remain_r      <= remain_nxt;
    added_r       <= added_nxt;
    dropped_r     <= dropped_nxt;
    out_addr_r    <= out_addr_nxt;
    out_granted_r <= out_granted_nxt;
    out_added_r   <= out_added_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_free_r    <= out_free_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_granted       = out_granted_r;
  assign out_pages_added   = out_added_r;
  assign out_pages_dropped = out_dropped_r;
  assign out_free_frames   = out_free_r;

endmodule

>>> rtl/core/page_frame_free_stack_unit.sv
// ----------------------------------------------------------------------------
// Page frame free stack unit
// LIFO allocator of physical page frames kept in a single-port frame RAM.
// ----------------------------------------------------------------------------
// Start an item with start while busy is low; each item gives one result,
// shown for one cycle with out_valid, and the receiver cannot stall it. A
// frame request updates the pointer and reads the RAM, then loads the
// result register. A request on an empty stack, or a registration that
// pushes nothing, loads the result register at once. A registration that
// pushes n pages makes one RAM write per page through the single RAM port.
// The result appears in the cycle after the item's last cycle. The frame
// RAM needs no clearing after reset. Configuration is taken while busy is low.
module page_frame_free_stack_unit
  import pffs_pkg::*;
#(
  parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  parameter int PAGE_SHIFT   = DEF_PAGE_SHIFT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_opcode,
  input  logic [ADDR_FIELD_W-1:0]  in_region_base,
  input  logic [ADDR_FIELD_W-1:0]  in_region_length,
  input  logic [TYPE_W-1:0]        in_region_type,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [TYPE_W-1:0]        cfg_usable_type_code,
  output logic                     out_valid,
  output logic [ADDR_FIELD_W-1:0]  out_frame_address,
  output logic                     out_granted,
  output logic [COUNT_FIELD_W-1:0] out_pages_added,
  output logic                     out_pages_dropped,
  output logic [COUNT_FIELD_W-1:0] out_free_frames
);

  localparam int FW = ADDRESS_BITS - PAGE_SHIFT;
  localparam int IW = $clog2(STACK_DEPTH);

  mem_ctl_t       mem_ctl;
  logic [IW-1:0]  mem_addr;
  logic [FW-1:0]  mem_wdata;
  logic [FW-1:0]  mem_rdata;

  // Sequencer and stack pointer.
  pffs_ctrl #(
    .STACK_DEPTH  (STACK_DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_region_base       (in_region_base),
    .in_region_length     (in_region_length),
    .in_region_type       (in_region_type),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_usable_type_code (cfg_usable_type_code),
    .out_valid            (out_valid),
    .out_frame_address    (out_frame_address),
    .out_granted          (out_granted),
    .out_pages_added      (out_pages_added),
    .out_pages_dropped    (out_pages_dropped),
    .out_free_frames      (out_free_frames),
    .mem_ctl              (mem_ctl),
    .mem_addr             (mem_addr),
    .mem_wdata            (mem_wdata),
    .mem_rdata            (mem_rdata)
  );

  // Frame number storage.
  pffs_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (FW)
  ) u_mem (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule

>>> rtl/core/pffs_check.sv
// ----------------------------------------------------------------------------
// Page frame free stack: port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_frame_free_stack_unit_macros.svh"

module pffs_check
  import pffs_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     in_opcode,
  input logic [ADDR_FIELD_W-1:0]  in_region_base,
  input logic [ADDR_FIELD_W-1:0]  in_region_length,
  input logic [TYPE_W-1:0]        in_region_type,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [TYPE_W-1:0]        cfg_usable_type_code,
  input logic                     out_valid,
  input logic [ADDR_FIELD_W-1:0]  out_frame_address,
  input logic                     out_granted,
  input logic [COUNT_FIELD_W-1:0] out_pages_added,
  input logic                     out_pages_dropped,
  input logic [COUNT_FIELD_W-1:0] out_free_frames
);

  // A result is shown only once the item's work is over.
  `PFFS_ASSERT_SAME(a_result_when_idle, clk, rst_n, out_valid, !busy, "result while busy")

  // The unit becomes busy only because an item was started.
  `PFFS_ASSERT_SAME(a_busy_from_start, clk, rst_n, $rose(busy), $past(start), "busy without start")

  // Every accepted item either keeps the unit busy or gives its result at once.
  `PFFS_ASSERT_NEXT(a_item_progress, clk, rst_n, start && !busy, busy || out_valid, "item lost")

  // A granted frame comes from a request, never from a registration.
  `PFFS_ASSERT_SAME(a_grant_is_request, clk, rst_n, out_valid && out_granted, (out_pages_added == '0) && !out_pages_dropped, "grant mixed with registration")

endmodule

bind page_frame_free_stack_unit pffs_check u_pffs_check (.*);
